FILE: rtl/core/bi2p_pkg.sv
// shared types, constants and helpers for the boolean infix to postfix converter
package bi2p_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH_DEF = 32;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// characters of interest
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_AND   = 8'h2A;
	localparam logic [7:0] CH_OR    = 8'h2B;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;

	// status codes
	localparam logic [1:0] ST_OK              = 2'd0;
	localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd1;
	localparam logic [1:0] ST_UNCLOSED_OPEN   = 2'd2;
	localparam logic [1:0] ST_OVERFLOW        = 2'd3;

	// stacked operators, ordered by weakness
	typedef enum logic [1:0] {
		OP_OPEN = 2'd0,
		OP_AND  = 2'd1,
		OP_OR   = 2'd2
	} op_t;

	// character kinds decided by the front
	typedef enum logic [2:0] {
		K_COMPL,
		K_OPERAND,
		K_OPEN,
		K_AND,
		K_OR,
		K_CLOSE,
		K_SKIP
	} kind_t;

	// class of the previously handled character
	typedef enum logic [2:0] {
		CL_OPERAND,
		CL_OPEN,
		CL_CLOSE,
		CL_COMPL,
		CL_OPER
	} class_t;

	// back sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_POP,
		S_PUSH,
		S_TAIL,
		S_CLOSE,
		S_LAST,
		S_MARK,
		S_FLUSH
	} state_t;

	// one classified character
	typedef struct packed {
		kind_t      kind;
		logic [7:0] character;
		logic       last;
	} q_entry_t;

	// front to queue
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	// queue to back
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	// printable form of a stacked operator
	function automatic logic [7:0] op_char(input op_t op);
		logic [7:0] c;
		case (op)
			OP_AND:  c = CH_AND;
			OP_OR:   c = CH_OR;
			OP_OPEN: c = CH_OPEN;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/bi2p_if.sv
// handshake channel interfaces for input characters and postfix results
interface bi2p_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_text;

	modport source(output valid, character, end_of_text, input ready);
	modport sink(input valid, character, end_of_text, output ready);
endinterface

interface bi2p_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] postfix_char;
	logic       has_char;
	logic       run_last;
	logic       expression_end;
	logic [1:0] status;

	modport source(output valid, postfix_char, has_char, run_last, expression_end, status,
		input ready);
	modport sink(input valid, postfix_char, has_char, run_last, expression_end, status,
		output ready);
endinterface

FILE: rtl/core/bi2p_front.sv
// front end: takes input beats and classifies each character
module bi2p_front (
	bi2p_in_if.sink          in_chan,
	input  logic             q_full,
	output bi2p_pkg::q_push_t push
);
	import bi2p_pkg::*;

	kind_t kind;
	logic  alpha;
	logic  digit;
	logic  keep;

	// character classification
	always_comb begin
		alpha = ((in_chan.character >= CH_UC_A) && (in_chan.character <= CH_UC_Z)) ||
			((in_chan.character >= CH_LC_A) && (in_chan.character <= CH_LC_Z));
		digit = (in_chan.character >= CH_DIG_0) && (in_chan.character <= CH_DIG_9);
		if (in_chan.character == CH_APOS) begin
			kind = K_COMPL;
		end else if (alpha || digit) begin
			kind = K_OPERAND;
		end else if (in_chan.character == CH_OPEN) begin
			kind = K_OPEN;
		end else if (in_chan.character == CH_AND) begin
			kind = K_AND;
		end else if (in_chan.character == CH_OR) begin
			kind = K_OR;
		end else if (in_chan.character == CH_CLOSE) begin
			kind = K_CLOSE;
		end else begin
			kind = K_SKIP;
		end
	end

	// skipped characters without end of text are dropped here
	assign keep = (kind != K_SKIP) || in_chan.end_of_text;

	// queue push
	assign in_chan.ready         = !q_full;
	assign push.valid            = in_chan.valid && !q_full && keep;
	assign push.entry.kind       = kind;
	assign push.entry.character  = in_chan.character;
	assign push.entry.last       = in_chan.end_of_text;
endmodule

FILE: rtl/core/bi2p_queue.sv
// short queue of classified characters between front and back
module bi2p_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  bi2p_pkg::q_push_t push,
	output logic              full,
	input  logic              pop,
	output bi2p_pkg::q_head_t head
);
	import bi2p_pkg::*;

	q_entry_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   fill_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (fill_q == QUEUE_CW'(QUEUE_DEPTH));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && (fill_q != '0);
	assign head.valid = (fill_q != '0);
	assign head.entry = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end
endmodule

FILE: rtl/core/bi2p_back.sv
// back end: operator stack sequencer, result hold stage and output register
module bi2p_back #(
	parameter int STACK_DEPTH = bi2p_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bi2p_pkg::q_head_t head,
	output logic              q_pop,
	bi2p_out_if.source        out_chan
);
	import bi2p_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	// sequencer and item state
	state_t     state_q, state_d;
	kind_t      kind_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       end_q;
	op_t        limit_q;
	state_t     after_q;
	class_t     prev_q;
	logic [1:0] err_q;

	// operator stack
	op_t            stack_mem [STACK_DEPTH];
	logic [CW-1:0]  count_q;
	op_t            top_q;
	logic           fresh_q;
	logic           base_open_q;
	op_t            rd_q;
	logic           rd_base_q;
	logic [CW-1:0]  count_m2;
	logic [IW-1:0]  rd_addr;
	op_t            top_w;
	logic           full;
	logic           pop_go;
	logic           implied;

	// hold stage and output register
	logic       hold_v_q;
	logic [7:0] hold_char_q;
	logic       hold_has_q;
	logic       hold_end_q;
	logic [1:0] hold_st_q;
	logic       out_v_q;
	logic [7:0] out_char_q;
	logic       out_has_q;
	logic       out_last_q;
	logic       out_end_q;
	logic [1:0] out_st_q;
	logic       out_free;
	logic       can_emit;
	logic       move;

	// actions of the current state
	logic       do_emit;
	logic [7:0] em_char;
	logic       em_has;
	logic       em_end;
	logic [1:0] em_st;
	logic       do_push;
	op_t        push_op;
	logic       do_pop;
	logic       err_set;
	logic [1:0] err_code;
	logic       prev_set;
	class_t     prev_val;
	logic       lim_set;
	op_t        lim_val;
	state_t     after_val;
	logic       end_set;
	logic       restart;
	logic       do_flush;

	// stack view
	assign count_m2 = count_q - CW'(2);
	assign rd_addr  = count_m2[IW-1:0];
	assign top_w    = fresh_q ? (rd_base_q ? OP_OPEN : rd_q) : top_q;
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign pop_go   = (count_q != '0) && (top_w != OP_OPEN) && (top_w <= limit_q);
	assign implied  = (prev_q == CL_OPERAND) || (prev_q == CL_CLOSE) || (prev_q == CL_COMPL);

	// result flow
	assign out_free = !out_v_q || out_chan.ready;
	assign can_emit = !hold_v_q || out_free;
	assign move     = (do_emit || do_flush) && hold_v_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (head.valid) state_d = S_START;
			end
			S_START: begin
				case (kind_q)
					K_COMPL: begin
						if (can_emit) state_d = S_LAST;
					end
					K_OPERAND: begin
						if (implied) state_d = S_POP;
						else if (can_emit) state_d = S_LAST;
					end
					K_OPEN: begin
						state_d = implied ? S_POP : S_LAST;
					end
					K_AND, K_OR, K_CLOSE: state_d = S_POP;
					default: state_d = S_LAST;
				endcase
			end
			S_POP: begin
				if (!pop_go) state_d = after_q;
			end
			S_PUSH: begin
				state_d = ((kind_q == K_OPERAND) || (kind_q == K_OPEN)) ? S_TAIL : S_LAST;
			end
			S_TAIL: begin
				if (kind_q != K_OPERAND || can_emit) state_d = S_LAST;
			end
			S_CLOSE: begin
				state_d = end_q ? S_MARK : S_LAST;
			end
			S_LAST: begin
				state_d = last_q ? S_POP : S_FLUSH;
			end
			S_MARK: begin
				if (can_emit) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (can_emit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state actions
	always_comb begin
		q_pop     = 1'b0;
		do_emit   = 1'b0;
		em_char   = char_q;
		em_has    = 1'b1;
		em_end    = 1'b0;
		em_st     = err_q;
		do_push   = 1'b0;
		push_op   = OP_AND;
		do_pop    = 1'b0;
		err_set   = 1'b0;
		err_code  = ST_UNMATCHED_CLOSE;
		prev_set  = 1'b0;
		prev_val  = CL_OPER;
		lim_set   = 1'b0;
		lim_val   = OP_AND;
		after_val = S_PUSH;
		end_set   = 1'b0;
		restart   = 1'b0;
		do_flush  = 1'b0;
		case (state_q)
			S_IDLE: begin
				q_pop = head.valid;
			end
			S_START: begin
				case (kind_q)
					K_COMPL: begin
						do_emit  = can_emit;
						prev_set = can_emit;
						prev_val = CL_COMPL;
					end
					K_OPERAND: begin
						if (implied) begin
							lim_set = 1'b1;
						end else begin
							do_emit  = can_emit;
							prev_set = can_emit;
							prev_val = CL_OPERAND;
						end
					end
					K_OPEN: begin
						if (implied) begin
							lim_set = 1'b1;
						end else begin
							do_push  = 1'b1;
							push_op  = OP_OPEN;
							prev_set = 1'b1;
							prev_val = CL_OPEN;
						end
					end
					K_AND: lim_set = 1'b1;
					K_OR: begin
						lim_set = 1'b1;
						lim_val = OP_OR;
					end
					K_CLOSE: begin
						lim_set   = 1'b1;
						lim_val   = OP_OR;
						after_val = S_CLOSE;
					end
					default: begin
						lim_set = 1'b0;
					end
				endcase
			end
			S_POP: begin
				if (pop_go && can_emit) begin
					do_emit = 1'b1;
					em_char = op_char(top_w);
					do_pop  = 1'b1;
				end
			end
			S_PUSH: begin
				do_push  = 1'b1;
				push_op  = (kind_q == K_OR) ? OP_OR : OP_AND;
				prev_set = (kind_q == K_AND) || (kind_q == K_OR);
			end
			S_TAIL: begin
				if (kind_q == K_OPERAND) begin
					do_emit  = can_emit;
					prev_set = can_emit;
					prev_val = CL_OPERAND;
				end else begin
					do_push  = 1'b1;
					push_op  = OP_OPEN;
					prev_set = 1'b1;
					prev_val = CL_OPEN;
				end
			end
			S_CLOSE: begin
				do_pop   = (count_q != '0);
				err_set  = (count_q == '0);
				prev_set = 1'b1;
				prev_val = CL_CLOSE;
			end
			S_LAST: begin
				if (last_q) begin
					lim_set   = 1'b1;
					lim_val   = OP_OR;
					after_val = S_CLOSE;
					end_set   = 1'b1;
				end
			end
			S_MARK: begin
				do_emit = can_emit;
				restart = can_emit;
				em_char = CH_NUL;
				em_has  = 1'b0;
				em_end  = 1'b1;
				em_st   = ((err_q == ST_OK) && (count_q != '0)) ? ST_UNCLOSED_OPEN : err_q;
			end
			S_FLUSH: begin
				do_flush = can_emit;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CW'(1);
			top_q       <= OP_OPEN;
			fresh_q     <= 1'b0;
			base_open_q <= 1'b1;
			prev_q      <= CL_OPEN;
			err_q       <= ST_OK;
			end_q       <= 1'b0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				count_q     <= CW'(1);
				top_q       <= OP_OPEN;
				fresh_q     <= 1'b0;
				base_open_q <= 1'b1;
				prev_q      <= CL_OPEN;
				err_q       <= ST_OK;
				end_q       <= 1'b0;
			end else begin
				fresh_q <= do_pop;
				top_q   <= top_w;
				if (do_push && !full) begin
					count_q <= count_q + 1'b1;
					top_q   <= push_op;
					if (count_q == '0) base_open_q <= 1'b0;
				end else if (do_pop) begin
					count_q <= count_q - 1'b1;
				end
				// first error wins
				if (err_q == ST_OK) begin
					if (do_push && full) err_q <= ST_OVERFLOW;
					else if (err_set) err_q <= err_code;
				end
				if (prev_set) prev_q <= prev_val;
				if (end_set) end_q <= 1'b1;
			end
			// hold and output valid
			if (do_emit) begin
				hold_v_q <= 1'b1;
			end else if (do_flush) begin
				hold_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= head.entry.kind;
			char_q <= head.entry.character;
			last_q <= head.entry.last;
		end
		if (lim_set) begin
			limit_q <= lim_val;
			after_q <= after_val;
		end
		if (do_emit) begin
			hold_char_q <= em_char;
			hold_has_q  <= em_has;
			hold_end_q  <= em_end;
			hold_st_q   <= em_st;
		end
		if (move) begin
			out_char_q <= hold_char_q;
			out_has_q  <= hold_has_q;
			out_end_q  <= hold_end_q;
			out_st_q   <= hold_st_q;
			out_last_q <= do_flush;
		end
	end

	// stack memory, read one below the top for the next pop
	always_ff @(posedge clk) begin
		if (do_push && !full) begin
			stack_mem[count_q[IW-1:0]] <= push_op;
		end
		rd_q      <= stack_mem[rd_addr];
		rd_base_q <= base_open_q && (rd_addr == '0);
	end

	// output beat
	assign out_chan.valid          = out_v_q;
	assign out_chan.postfix_char   = out_char_q;
	assign out_chan.has_char       = out_has_q;
	assign out_chan.run_last       = out_last_q;
	assign out_chan.expression_end = out_end_q;
	assign out_chan.status         = out_st_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_v_q)
		else $error("result held across items");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_end_q) |-> out_last_q)
		else $error("end marker not flagged as last result");

	a_fresh_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> $past(do_pop))
		else $error("stack top refresh without pop");

	a_pop_guard: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head.valid)
		else $error("queue read while empty");
endmodule

FILE: rtl/core/bool_infix_to_postfix.sv
// top level of the boolean infix to postfix converter
//
// channel   dir  payload                                                   beat on
// in_chan   in   character[7:0], end_of_text                               valid & ready
// out_chan  out  postfix_char[7:0], has_char, run_last, expression_end,    valid & ready
//                status[1:0]
//
// every character walks the back sequencer from S_START to S_LAST, passing through S_POP
// for an operator, a closing parenthesis or an implied and, with one emit for every operator
// popped; skipped characters are dropped before the queue unless they carry end of text
// the end-of-text character adds a closing-parenthesis pass and the end marker
// reset is asynchronous; the stack memory has no reset and needs no clearing pass
// a four-entry queue takes input beats while the back works; output stalls hold the back
module bool_infix_to_postfix #(
	parameter int STACK_DEPTH = bi2p_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bi2p_in_if.sink    in_chan,
	bi2p_out_if.source out_chan
);
	import bi2p_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    q_pop;

	// classification
	bi2p_front u_front (
		.in_chan (in_chan),
		.q_full  (q_full),
		.push    (push)
	);

	// decoupling queue
	bi2p_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (q_pop),
		.head   (head)
	);

	// stack sequencer
	bi2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_pop    (q_pop),
		.out_chan (out_chan)
	);
endmodule
